/* design/id3fs_pkg.sv */
// Shared types and constants for the ID3v2 title frame scanner.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none

package id3fs_pkg;

  localparam int FRAME_HDR_BYTES = 10;
  localparam int HDR_IDX_W       = 4;
  localparam int OUT_W           = 28;

  localparam logic [31:0] TITLE_ID     = 32'h5449_5432;  // "TIT2"
  localparam logic [7:0]  SYNCSAFE_TOP = 8'h80;
  localparam logic [2:0]  VER_SYNCSAFE = 3'd4;
  localparam logic [2:0]  VER_RESET    = 3'd4;

  typedef logic [OUT_W-1:0] out_word_t;

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_NONE    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] tag_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    status_e   scan_status;
    out_word_t frame_offset;
    out_word_t title_length;
  } result_t;

endpackage

`default_nettype wire

/* design/id3fs_in_stage.sv */
// Input register for tag body items, holds an item until the scanner takes it.
// Depends on id3fs_pkg (item_t).
`default_nettype none

module id3fs_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire id3fs_pkg::item_t item_i,
  input  wire logic          take_i,     // scanner consumes the held item
  output logic               valid_o,
  output id3fs_pkg::item_t   item_o
);

  logic             valid_q, valid_d;
  id3fs_pkg::item_t item_q;
  logic             load;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

/* design/id3fs_scan.sv */
// Frame header walker: per-byte state update and end-of-body result.
// Depends on id3fs_pkg (item_t, result_t, status codes, constants).
`default_nettype none

module id3fs_scan #(
  parameter int POSITION_BITS = 28
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               fire_i,
  input  wire id3fs_pkg::item_t   item_i,
  input  wire logic [2:0]         tag_version_i,
  output logic                    res_valid_o,
  output id3fs_pkg::result_t      res_o
);

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [id3fs_pkg::HDR_IDX_W-1:0] idx_t;

  typedef enum logic [5:0] {
    PH_HEADER     = 6'b000001,
    PH_PAYLOAD    = 6'b000010,
    PH_PADDING    = 6'b000100,
    PH_TITLE      = 6'b001000,
    PH_TITLE_DONE = 6'b010000,
    PH_INVALID    = 6'b100000
  } phase_e;

  localparam idx_t LAST_HDR_IDX = idx_t'(id3fs_pkg::FRAME_HDR_BYTES - 1);

  pos_t        byte_pos_q, byte_pos_d;
  pos_t        frame_start_q, frame_start_d;
  idx_t        hdr_idx_q, hdr_idx_d;
  logic [31:0] id_q, id_d;
  logic [31:0] size_q, size_d;
  logic [31:0] remain_q, remain_d;
  phase_e      phase_q, phase_d;
  pos_t        found_off_q, found_off_d;
  pos_t        found_len_q, found_len_d;

  logic        hdr_ok;
  logic        char_ok;
  logic        is_title;
  logic [7:0]  b;

  assign b        = item_i.tag_byte;
  assign char_ok  = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h30 && b <= 8'h39);
  assign is_title = (id_q == id3fs_pkg::TITLE_ID);

  always_comb begin
    byte_pos_d    = byte_pos_q;
    frame_start_d = frame_start_q;
    hdr_idx_d     = hdr_idx_q;
    id_d          = id_q;
    size_d        = size_q;
    remain_d      = remain_q;
    phase_d       = phase_q;
    found_off_d   = found_off_q;
    found_len_d   = found_len_q;
    hdr_ok        = 1'b1;
    res_valid_o   = 1'b0;
    res_o         = '{scan_status: id3fs_pkg::ST_INVALID, frame_offset: '0, title_length: '0};

    if (fire_i) begin
      byte_pos_d = byte_pos_q + 1'b1;
      unique case (phase_q)
        PH_HEADER: begin
          if (hdr_idx_q == '0) begin
            frame_start_d = byte_pos_q;
          end
          if (hdr_idx_q == '0 && b == 8'h00) begin
            phase_d = PH_PADDING;
          end else begin
            if (hdr_idx_q < idx_t'(4)) begin
              if (!char_ok) begin
                hdr_ok = 1'b0;
              end else begin
                id_d = {id_q[23:0], b};
              end
            end else if (hdr_idx_q < idx_t'(8)) begin
              if (tag_version_i == id3fs_pkg::VER_SYNCSAFE) begin
                if ((b & id3fs_pkg::SYNCSAFE_TOP) != 8'h00) begin
                  hdr_ok = 1'b0;
                end else begin
                  size_d = {size_q[24:0], b[6:0]};
                end
              end else begin
                size_d = {size_q[23:0], b};
              end
            end else if (is_title && b != 8'h00) begin
              hdr_ok = 1'b0;  // title flags must be clear
            end

            if (!hdr_ok) begin
              phase_d = PH_INVALID;
            end else if (hdr_idx_q != LAST_HDR_IDX) begin
              hdr_idx_d = hdr_idx_q + 1'b1;
            end else begin
              hdr_idx_d = '0;
              remain_d  = size_q;
              if (is_title) begin
                found_off_d = frame_start_q;
                found_len_d = pos_t'(33'(size_q) + 33'(id3fs_pkg::FRAME_HDR_BYTES));
                phase_d     = (size_q != '0) ? PH_TITLE : PH_TITLE_DONE;
              end else begin
                phase_d     = (size_q != '0) ? PH_PAYLOAD : PH_HEADER;
              end
              id_d   = '0;
              size_d = '0;
            end
          end
        end
        PH_PAYLOAD: begin
          remain_d = remain_q - 1'b1;
          if (remain_q == 32'd1) begin
            phase_d = PH_HEADER;
          end
        end
        PH_TITLE: begin
          remain_d = remain_q - 1'b1;
          if (remain_q == 32'd1) begin
            phase_d = PH_TITLE_DONE;
          end
        end
        PH_PADDING: begin
          if (b != 8'h00) begin
            phase_d = PH_INVALID;
          end
        end
        PH_TITLE_DONE: begin
          phase_d = PH_TITLE_DONE;
        end
        default: begin
          phase_d = PH_INVALID;
        end
      endcase

      if (item_i.last_byte) begin
        res_valid_o = 1'b1;
        priority if (phase_d == PH_HEADER && hdr_idx_d == '0) begin
          res_o.scan_status  = id3fs_pkg::ST_NONE;
          res_o.frame_offset = id3fs_pkg::out_word_t'(byte_pos_d);
        end else if (phase_d == PH_PADDING) begin
          res_o.scan_status  = id3fs_pkg::ST_NONE;
          res_o.frame_offset = id3fs_pkg::out_word_t'(frame_start_d);
        end else if (phase_d == PH_TITLE_DONE) begin
          res_o.scan_status  = id3fs_pkg::ST_FOUND;
          res_o.frame_offset = id3fs_pkg::out_word_t'(found_off_d);
          res_o.title_length = id3fs_pkg::out_word_t'(found_len_d);
        end else begin
          res_o.scan_status  = id3fs_pkg::ST_INVALID;
        end
        // back to the start-of-body state for the next tag
        byte_pos_d    = '0;
        frame_start_d = '0;
        hdr_idx_d     = '0;
        id_d          = '0;
        size_d        = '0;
        remain_d      = '0;
        phase_d       = PH_HEADER;
        found_off_d   = '0;
        found_len_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q    <= '0;
      frame_start_q <= '0;
      hdr_idx_q     <= '0;
      id_q          <= '0;
      size_q        <= '0;
      remain_q      <= '0;
      phase_q       <= PH_HEADER;
      found_off_q   <= '0;
      found_len_q   <= '0;
    end else begin
      byte_pos_q    <= byte_pos_d;
      frame_start_q <= frame_start_d;
      hdr_idx_q     <= hdr_idx_d;
      id_q          <= id_d;
      size_q        <= size_d;
      remain_q      <= remain_d;
      phase_q       <= phase_d;
      found_off_q   <= found_off_d;
      found_len_q   <= found_len_d;
    end
  end

endmodule

`default_nettype wire

/* design/id3fs_out_stage.sv */
// Result register on the output channel; frees up as soon as the receiver takes.
// Depends on id3fs_pkg (result_t).
`default_nettype none

module id3fs_out_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire id3fs_pkg::result_t res_i,
  output logic                    free_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output id3fs_pkg::result_t      res_o
);

  logic               valid_q, valid_d;
  id3fs_pkg::result_t res_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

/* design/id3v2_title_frame_scanner_top.sv */
// Top level of the ID3v2 title frame scanner: input register, scanner, result register.
// Depends on id3fs_pkg, id3fs_in_stage, id3fs_scan and id3fs_out_stage.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one tag body byte per item,
//   with last_byte_i set on the final byte of the body. Every byte is absorbed;
//   only the last one produces a result item on the output channel
//   (out_valid_o / out_stall_i): scan_status_o, frame_offset_o, title_length_o.
//   Config channel (cfg_valid_i / cfg_ready_o) writes tag_version; it is always
//   ready and should only be written between tags.
// Timing:
//   The accepting edge loads the input register; the take runs the header walk
//   and loads a final byte's result. Throughput is one byte per cycle, set by
//   the single-byte state update of the scanner, while no final byte waits on a
//   busy result register; byte counters and size fields are updated in that step.
// Stalls:
//   While a result waits under out_stall_i, ordinary bytes keep flowing; only
//   a final byte holds in the input register until the result register frees.
// Reset:
//   rst_ni (async, low) empties both registers, returns the walk to the start
//   of a body and sets tag_version to 4 (syncsafe sizes). After each result the
//   walk also restarts, ready for the next tag body.
`default_nettype none

module id3v2_title_frame_scanner_top #(
  parameter int POSITION_BITS = 28
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // tag byte channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  tag_byte_i,
  input  wire logic        last_byte_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       scan_status_o,
  output logic [27:0]      frame_offset_o,
  output logic [27:0]      title_length_o,
  // configuration channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  tag_version_i
);

  logic               in_valid_q;
  id3fs_pkg::item_t   in_item;
  id3fs_pkg::item_t   held_item;
  logic               take;
  logic               out_free;
  logic               res_valid;
  id3fs_pkg::result_t res;
  id3fs_pkg::result_t out_res;
  logic [2:0]         tag_version_q;

  // config register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_version_q <= id3fs_pkg::VER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tag_version_q <= tag_version_i;
    end
  end

  assign in_item.tag_byte  = tag_byte_i;
  assign in_item.last_byte = last_byte_i;

  // a non-final byte never produces a result, so it need not wait on the output
  assign take = in_valid_q && (!held_item.last_byte || out_free);

  id3fs_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .take_i     (take),
    .valid_o    (in_valid_q),
    .item_o     (held_item)
  );

  id3fs_scan #(
    .POSITION_BITS (POSITION_BITS)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (take),
    .item_i        (held_item),
    .tag_version_i (tag_version_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  id3fs_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign scan_status_o  = out_res.scan_status;
  assign frame_offset_o = out_res.frame_offset;
  assign title_length_o = out_res.title_length;

`ifndef ASSERT_OFF
  // a new result never overwrites one the receiver has not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_valid |-> out_free)
    else $error("result produced while result register busy");

  // a final byte waits behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i && in_valid_q && held_item.last_byte) |-> in_stall_o)
    else $error("final byte not held behind stalled result");

  // results come only from final bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (take && held_item.last_byte))
    else $error("result without a final byte");

  // the input side stalls only while it holds an item
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> in_valid_q)
    else $error("stall with empty input register");
`endif

endmodule

`default_nettype wire
